[rtl/scan_footprint_line_selector_top_defines.svh]
// assertion macros used by the checker file
`ifndef SCAN_FOOTPRINT_LINE_SELECTOR_TOP_DEFINES_SVH
`define SCAN_FOOTPRINT_LINE_SELECTOR_TOP_DEFINES_SVH

// property that holds in the same cycle as its antecedent
`define SFLS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// property that holds in the cycle after its antecedent
`define SFLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

[rtl/sfls_pkg.sv]
package sfls_pkg;

   // pixel index saturates at this count
   localparam int MAX_PIXELS = 4096;
   localparam int PIX_CNT_W  = $clog2(MAX_PIXELS + 1);
   localparam int PPS_W      = 13;
   localparam int CNT_CMP_W  = (PIX_CNT_W > PPS_W) ? PIX_CNT_W : PPS_W;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_LAT_STEP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_SPACE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIX_SCAN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NAV_MASK  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_DIR  = 3'd4;

   // reason codes of an emitted line
   localparam logic [1:0] WHY_FIRST = 2'd0;
   localparam logic [1:0] WHY_STEP  = 2'd1;
   localparam logic [1:0] WHY_TURN  = 2'd2;
   localparam logic [1:0] WHY_FINAL = 2'd3;

   // heading codes, two's complement of +1 / -1
   localparam logic [1:0] HEAD_UNKNOWN = 2'b00;
   localparam logic [1:0] HEAD_ASC     = 2'b01;
   localparam logic [1:0] HEAD_DESC    = 2'b11;

   // Q16.16 degree limits
   localparam logic signed [31:0] LAT_MAX     = 32'sd5898240;
   localparam logic signed [31:0] LAT_MIN     = -32'sd5898240;
   localparam logic signed [31:0] LON_MAX     = 32'sd11796480;
   localparam logic signed [31:0] LON_MIN     = -32'sd11796480;
   localparam logic signed [31:0] POLE_LAT    = 32'sd4915200;
   localparam logic signed [31:0] POLE_LAT_N  = -32'sd4915200;
   localparam logic signed [31:0] REF_LAT_RST = -32'sd65470464;

   typedef struct packed {
      logic [23:0]      lat_step_threshold;
      logic [15:0]      direction_spacing;
      logic [PPS_W-1:0] pixels_per_scan;
      logic [31:0]      nav_fail_mask;
      logic             scans_right;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] lat;
      logic signed [31:0] lon;
      logic [15:0]        scan;
      logic               eos;
      logic               fin;
      logic               pre_good;
   } pixel_type;

   typedef struct packed {
      logic               emit;
      logic [1:0]         why;
      logic signed [31:0] start_lat;
      logic signed [31:0] start_lon;
      logic signed [31:0] end_lat;
      logic signed [31:0] end_lon;
      logic signed [31:0] centre_lat;
      logic [15:0]        line_number;
   } line_type;

endpackage

[rtl/scan_footprint_line_selector_top.sv]
// Scan footprint line selector. Geolocated pixels stream in one beat per cycle on req_,
// scan line by scan line; on the beat that ends a scan the block may return one line
// beat on rsp_ (endpoints, centre latitude, scan number and reason code). A pixel
// passes an input register, where flag and coordinate checks are made, and then the
// scan tracker, which updates its state and loads the response register, from which
// the line is offered. Throughput is one pixel per cycle; the input side stalls only
// while a line waits in the response register and the pixel stage is full. The user
// must write configuration registers through csr_ only while no pixel is in flight;
// the block itself does not enforce this.
module scan_footprint_line_selector_top
   import sfls_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [31:0]    req_pixel_lat,
   input  logic signed [31:0]    req_pixel_lon,
   input  logic [31:0]           req_pixel_flags,
   input  logic [15:0]           req_scan_number,
   input  logic                  req_end_of_scan,
   input  logic                  req_final_scan,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [31:0]    rsp_start_lat,
   output logic signed [31:0]    rsp_start_lon,
   output logic signed [31:0]    rsp_end_lat,
   output logic signed [31:0]    rsp_end_lon,
   output logic signed [31:0]    rsp_centre_lat,
   output logic [15:0]           rsp_line_number,
   output logic [1:0]            rsp_why
);

   cfg_type   cfg;
   pixel_type pix;
   line_type  line;
   logic      pix_vld;
   logic      adv;
   logic      rsp_valid_ff, rsp_valid_in;
   line_type  rsp_ff, rsp_in;

   sfls_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sfls_pixel_stage u_pixel (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_lat   (req_pixel_lat),
      .req_pixel_lon   (req_pixel_lon),
      .req_pixel_flags (req_pixel_flags),
      .req_scan_number (req_scan_number),
      .req_end_of_scan (req_end_of_scan),
      .req_final_scan  (req_final_scan),
      .adv             (adv),
      .pix_vld         (pix_vld),
      .pix             (pix)
   );

   sfls_line_tracker u_tracker (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .adv   (adv),
      .pix   (pix),
      .line  (line)
   );

   // pixel moves on when the response slot is free or being emptied
   assign adv = pix_vld && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = adv ? line.emit : (rsp_valid_ff && !rsp_ready);

   // swap endpoints for right-scanning instruments
   always_comb begin
      rsp_in = line;
      if (cfg.scans_right) begin
         rsp_in.start_lat = line.end_lat;
         rsp_in.start_lon = line.end_lon;
         rsp_in.end_lat   = line.start_lat;
         rsp_in.end_lon   = line.start_lon;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && line.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_start_lat   = rsp_ff.start_lat;
   assign rsp_start_lon   = rsp_ff.start_lon;
   assign rsp_end_lat     = rsp_ff.end_lat;
   assign rsp_end_lon     = rsp_ff.end_lon;
   assign rsp_centre_lat  = rsp_ff.centre_lat;
   assign rsp_line_number = rsp_ff.line_number;
   assign rsp_why         = rsp_ff.why;

endmodule

[rtl/sfls_csr_regs.sv]
module sfls_csr_regs
   import sfls_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_LAT_STEP:  cfg_in.lat_step_threshold = csr_wdata[23:0];
            CSR_DIR_SPACE: cfg_in.direction_spacing  = csr_wdata[15:0];
            CSR_PIX_SCAN:  cfg_in.pixels_per_scan    = csr_wdata[PPS_W-1:0];
            CSR_NAV_MASK:  cfg_in.nav_fail_mask      = csr_wdata;
            CSR_SCAN_DIR:  cfg_in.scans_right        = csr_wdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lat_step_threshold <= 24'd65536;
         cfg_ff.direction_spacing  <= 16'd5;
         cfg_ff.pixels_per_scan    <= PPS_W'(1024);
         cfg_ff.nav_fail_mask      <= '0;
         cfg_ff.scans_right        <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/sfls_pixel_stage.sv]
module sfls_pixel_stage
   import sfls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_pixel_lat,
   input  logic [31:0] req_pixel_lon,
   input  logic [31:0] req_pixel_flags,
   input  logic [15:0] req_scan_number,
   input  logic        req_end_of_scan,
   input  logic        req_final_scan,
   input  logic        adv,
   output logic        pix_vld,
   output pixel_type   pix
);

   logic      pix_vld_ff;
   logic      pix_vld_in;
   pixel_type pix_ff;
   pixel_type pix_in;
   logic      take;

   // stage is free when empty or moving on this cycle
   assign req_ready = !pix_vld_ff || adv;
   assign take      = req_valid && req_ready;
   assign pix_vld_in = take || (pix_vld_ff && !adv);

   // flag and coordinate checks, index check comes later
   always_comb begin
      pix_in.lat  = $signed(req_pixel_lat);
      pix_in.lon  = $signed(req_pixel_lon);
      pix_in.scan = req_scan_number;
      pix_in.eos  = req_end_of_scan;
      pix_in.fin  = req_final_scan;
      pix_in.pre_good = ((req_pixel_flags & cfg.nav_fail_mask) == 32'd0)
         && ($signed(req_pixel_lat) <= LAT_MAX) && ($signed(req_pixel_lat) >= LAT_MIN)
         && ($signed(req_pixel_lon) <= LON_MAX) && ($signed(req_pixel_lon) >= LON_MIN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_vld_ff <= 1'b0;
      end else begin
         pix_vld_ff <= pix_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pix_ff <= pix_in;
      end
   end

   assign pix_vld = pix_vld_ff;
   assign pix     = pix_ff;

endmodule

[rtl/sfls_line_tracker.sv]
module sfls_line_tracker
   import sfls_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      adv,
   input  pixel_type pix,
   output line_type  line
);

   logic [PIX_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 has_good_ff, has_good_in;
   logic                 centre_found_ff, centre_found_in;
   logic signed [31:0]   cs_lat_ff, cs_lat_in, cs_lon_ff, cs_lon_in;
   logic signed [31:0]   ce_lat_ff, ce_lat_in, ce_lon_ff, ce_lon_in;
   logic signed [31:0]   cc_lat_ff, cc_lat_in;
   logic signed [31:0]   hs_lat_ff, hs_lat_in, hs_lon_ff, hs_lon_in;
   logic signed [31:0]   he_lat_ff, he_lat_in, he_lon_ff, he_lon_in;
   logic signed [31:0]   hc_lat_ff, hc_lat_in;
   logic                 seen_ff, seen_in;
   logic signed [31:0]   ref_lat_ff, ref_lat_in;
   logic [1:0]           prev_head_ff, prev_head_in;
   logic [15:0]          sample_scan_ff, sample_scan_in;

   logic [CNT_CMP_W-1:0] idx_x, pps_x, half_x, max_x;
   logic                 good, take_centre, scan_good;
   logic signed [31:0]   cen;
   logic signed [32:0]   lat_diff, lat_dist;
   logic [15:0]          scan_gap;
   logic                 sampled, step, turn, pole;
   logic [1:0]           head, prev_eff, head_neg;

   // pixel index checks against the scan length
   assign idx_x  = CNT_CMP_W'(cnt_ff);
   assign pps_x  = CNT_CMP_W'(cfg.pixels_per_scan);
   assign half_x = CNT_CMP_W'(cfg.pixels_per_scan[PPS_W-1:1]);
   assign max_x  = CNT_CMP_W'(MAX_PIXELS);
   assign good   = pix.pre_good && (idx_x < pps_x) && (idx_x < max_x);
   assign take_centre = good && ((idx_x <= half_x) || !centre_found_ff);
   assign scan_good   = has_good_ff || good;

   // candidates including this pixel
   assign cs_lat_in = (good && !has_good_ff) ? pix.lat : cs_lat_ff;
   assign cs_lon_in = (good && !has_good_ff) ? pix.lon : cs_lon_ff;
   assign ce_lat_in = good ? pix.lat : ce_lat_ff;
   assign ce_lon_in = good ? pix.lon : ce_lon_ff;
   assign cc_lat_in = take_centre ? pix.lat : cc_lat_ff;
   assign cen       = cc_lat_in;

   // heading sample and latitude change
   assign scan_gap = pix.scan - sample_scan_ff;
   assign sampled  = scan_gap > cfg.direction_spacing;
   assign head     = !sampled ? HEAD_UNKNOWN : ((cen > ref_lat_ff) ? HEAD_ASC : HEAD_DESC);
   assign prev_eff = (sampled && (prev_head_ff == HEAD_UNKNOWN)) ? head : prev_head_ff;
   assign head_neg = 2'(~head + 2'd1);
   assign lat_diff = 33'(ref_lat_ff) - 33'(cen);
   assign lat_dist = lat_diff[32] ? -lat_diff : lat_diff;
   assign step     = lat_dist > $signed({9'd0, cfg.lat_step_threshold});
   assign pole     = (cen > POLE_LAT) || (cen < POLE_LAT_N);
   assign turn     = (head != HEAD_UNKNOWN) && (prev_eff == head_neg) && pole;

   // next state and line decision
   always_comb begin
      cnt_in          = cnt_ff;
      has_good_in     = has_good_ff;
      centre_found_in = centre_found_ff;
      hs_lat_in       = hs_lat_ff;
      hs_lon_in       = hs_lon_ff;
      he_lat_in       = he_lat_ff;
      he_lon_in       = he_lon_ff;
      hc_lat_in       = hc_lat_ff;
      seen_in         = seen_ff;
      ref_lat_in      = ref_lat_ff;
      prev_head_in    = prev_head_ff;
      sample_scan_in  = sample_scan_ff;
      line.emit       = 1'b0;
      line.why        = WHY_FINAL;

      if (adv) begin
         has_good_in     = scan_good;
         centre_found_in = centre_found_ff || good;
         if (cnt_ff < PIX_CNT_W'(MAX_PIXELS)) begin
            cnt_in = cnt_ff + PIX_CNT_W'(1);
         end
         if (pix.eos) begin
            cnt_in          = '0;
            has_good_in     = 1'b0;
            centre_found_in = 1'b0;
            if (scan_good) begin
               hs_lat_in = cs_lat_in;
               hs_lon_in = cs_lon_in;
               he_lat_in = ce_lat_in;
               he_lon_in = ce_lon_in;
               hc_lat_in = cen;
               if (!seen_ff) begin
                  seen_in        = 1'b1;
                  ref_lat_in     = cen;
                  sample_scan_in = pix.scan;
                  line.emit      = 1'b1;
                  line.why       = WHY_FIRST;
               end else begin
                  if (sampled) begin
                     sample_scan_in = pix.scan;
                  end
                  prev_head_in = prev_eff;
                  if (step) begin
                     prev_head_in = head;
                     ref_lat_in   = cen;
                     line.emit    = 1'b1;
                     line.why     = WHY_STEP;
                  end else if (turn) begin
                     prev_head_in = head;
                     ref_lat_in   = cen;
                     line.emit    = 1'b1;
                     line.why     = WHY_TURN;
                  end
               end
            end
            if (!line.emit && pix.fin) begin
               line.emit = 1'b1;
               line.why  = WHY_FINAL;
            end
         end
      end

      // endpoints come from the held bounds after this scan's update
      line.start_lat   = hs_lat_in;
      line.start_lon   = hs_lon_in;
      line.end_lat     = he_lat_in;
      line.end_lon     = he_lon_in;
      line.centre_lat  = hc_lat_in;
      line.line_number = pix.scan;
   end

   // control and decision state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff          <= '0;
         has_good_ff     <= 1'b0;
         centre_found_ff <= 1'b0;
         hs_lat_ff       <= '0;
         hs_lon_ff       <= '0;
         he_lat_ff       <= '0;
         he_lon_ff       <= '0;
         hc_lat_ff       <= '0;
         seen_ff         <= 1'b0;
         ref_lat_ff      <= REF_LAT_RST;
         prev_head_ff    <= HEAD_UNKNOWN;
         sample_scan_ff  <= '0;
      end else begin
         cnt_ff          <= cnt_in;
         has_good_ff     <= has_good_in;
         centre_found_ff <= centre_found_in;
         hs_lat_ff       <= hs_lat_in;
         hs_lon_ff       <= hs_lon_in;
         he_lat_ff       <= he_lat_in;
         he_lon_ff       <= he_lon_in;
         hc_lat_ff       <= hc_lat_in;
         seen_ff         <= seen_in;
         ref_lat_ff      <= ref_lat_in;
         prev_head_ff    <= prev_head_in;
         sample_scan_ff  <= sample_scan_in;
      end
   end

   // scan candidates, always written before they are read
   always_ff @(posedge clock) begin
      if (adv) begin
         cs_lat_ff <= cs_lat_in;
         cs_lon_ff <= cs_lon_in;
         ce_lat_ff <= ce_lat_in;
         ce_lon_ff <= ce_lon_in;
         cc_lat_ff <= cc_lat_in;
      end
   end

endmodule

[rtl/sfls_checker.sv]
`include "scan_footprint_line_selector_top_defines.svh"

module sfls_checker
   import sfls_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_end_of_scan,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic signed [31:0]    rsp_start_lat,
   input logic signed [31:0]    rsp_start_lon,
   input logic signed [31:0]    rsp_end_lat,
   input logic signed [31:0]    rsp_end_lon,
   input logic signed [31:0]    rsp_centre_lat,
   input logic [15:0]           rsp_line_number,
   input logic [1:0]            rsp_why
);

   logic [177:0] rsp_beat;
   logic         eos_beat;

   // whole line beat payload and accepted end-of-scan pixel
   assign rsp_beat = {rsp_start_lat, rsp_start_lon, rsp_end_lat, rsp_end_lon,
                      rsp_centre_lat, rsp_line_number, rsp_why};
   assign eos_beat = req_valid && req_ready && req_end_of_scan;

   // a stalled line beat stays up
   `SFLS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a stalled line beat keeps its payload
   `SFLS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_beat))

   // input stalls only behind a waiting line beat
   `SFLS_ASSERT_NOW(a_req_backpressure, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // a new line beat follows an accepted end-of-scan pixel through the pixel and response registers
   `SFLS_ASSERT_NOW(a_rsp_from_eos, clock, reset, $rose(rsp_valid), $past(eos_beat, 2))

endmodule

bind scan_footprint_line_selector_top sfls_checker u_sfls_checker (.*);

[bench/sfls_line_checker.sv]
module sfls_line_checker
   import sfls_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic signed [31:0]    req_pixel_lat,
   input  logic signed [31:0]    req_pixel_lon,
   input  logic [31:0]           req_pixel_flags,
   input  logic [15:0]           req_scan_number,
   input  logic                  req_end_of_scan,
   input  logic                  req_final_scan,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic signed [31:0]    rsp_start_lat,
   input  logic signed [31:0]    rsp_start_lon,
   input  logic signed [31:0]    rsp_end_lat,
   input  logic signed [31:0]    rsp_end_lon,
   input  logic signed [31:0]    rsp_centre_lat,
   input  logic [15:0]           rsp_line_number,
   input  logic [1:0]            rsp_why,
   output int                    fail_count,
   output int                    lines_pending,
   output int                    lines_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   // register copies
   logic [23:0]        step_thr;
   logic [15:0]        head_gap;
   logic [PPS_W-1:0]   scan_width;
   logic [31:0]        fail_mask;
   logic               right_scan;

   // current scan
   logic [PPS_W-1:0]   pix_idx;
   bit                 has_good;
   bit                 centre_set;
   logic signed [31:0] first_lat, first_lon, tail_lat, tail_lon, mid_lat;

   // bounds of the last good scan and the heading tracker
   logic signed [31:0] keep_slat, keep_slon, keep_elat, keep_elon, keep_mid;
   bit                 any_good_scan;
   logic signed [31:0] ref_lat;
   logic [1:0]         last_head;
   logic [15:0]        head_scan;

   line_type           lines_due[$];
   line_type           next_line;
   line_type           oldest;

   function automatic void clear_scan();
      pix_idx    = '0;
      has_good   = 0;
      centre_set = 0;
      first_lat  = '0;
      first_lon  = '0;
      tail_lat   = '0;
      tail_lon   = '0;
      mid_lat    = '0;
   endfunction

   // one pixel through the tracker; returns 1 when a line is due
   function automatic bit track_pixel(input logic signed [31:0] lat,
                                      input logic signed [31:0] lon,
                                      input logic [31:0] flags,
                                      input logic [15:0] scan,
                                      input bit eos,
                                      input bit fin,
                                      output line_type line);
      bit                 good;
      bit                 emit;
      logic [1:0]         why;
      logic [1:0]         head;
      logic signed [31:0] c;
      longint             delta;
      longint             mag;
      emit = 0;
      why  = WHY_FIRST;
      line = '0;
      good = ((flags & fail_mask) == 0)
             && lat <= LAT_MAX && lat >= LAT_MIN
             && lon <= LON_MAX && lon >= LON_MIN
             && pix_idx < scan_width && pix_idx < MAX_PIXELS;
      if (good) begin
         if (!has_good) begin
            first_lat = lat;
            first_lon = lon;
         end
         has_good = 1;
         tail_lat = lat;
         tail_lon = lon;
         if (pix_idx <= scan_width / 2 || !centre_set) begin
            mid_lat    = lat;
            centre_set = 1;
         end
      end
      if (pix_idx < MAX_PIXELS) pix_idx++;
      if (!eos) return 0;

      // scan end decision
      if (has_good) begin
         c         = mid_lat;
         keep_slat = first_lat;
         keep_slon = first_lon;
         keep_elat = tail_lat;
         keep_elon = tail_lon;
         keep_mid  = c;
         if (!any_good_scan) begin
            any_good_scan = 1;
            ref_lat       = c;
            head_scan     = scan;
            emit          = 1;
            why           = WHY_FIRST;
         end else begin
            head = HEAD_UNKNOWN;
            if (16'(scan - head_scan) > head_gap) begin
               head_scan = scan;
               head = (longint'(c) - longint'(ref_lat) > 0) ? HEAD_ASC : HEAD_DESC;
               if (last_head == HEAD_UNKNOWN) last_head = head;
            end
            delta = longint'(ref_lat) - longint'(c);
            if (delta < 0) delta = -delta;
            mag = longint'(c);
            if (mag < 0) mag = -mag;
            if (delta > longint'(step_thr)) begin
               last_head = head;
               ref_lat   = c;
               emit      = 1;
               why       = WHY_STEP;
            end else if (head != HEAD_UNKNOWN
                         && last_head == ((head == HEAD_ASC) ? HEAD_DESC : HEAD_ASC)
                         && mag > longint'(POLE_LAT)) begin
               last_head = head;
               ref_lat   = c;
               emit      = 1;
               why       = WHY_TURN;
            end
         end
      end
      if (!emit && fin) begin
         emit = 1;
         why  = WHY_FINAL;
      end
      clear_scan();
      if (!emit) return 0;

      // right scanning swaps the endpoints, never the centre
      line.emit        = 1;
      line.why         = why;
      line.start_lat   = right_scan ? keep_elat : keep_slat;
      line.start_lon   = right_scan ? keep_elon : keep_slon;
      line.end_lat     = right_scan ? keep_slat : keep_elat;
      line.end_lon     = right_scan ? keep_slon : keep_elon;
      line.centre_lat  = keep_mid;
      line.line_number = scan;
      return 1;
   endfunction

   function automatic void check_field(input string name,
                                       input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // predict on pixel beats, compare on line beats
   always @(posedge clock) begin
      if (reset) begin
         step_thr      = 24'd65536;
         head_gap      = 16'd5;
         scan_width    = 13'd1024;
         fail_mask     = '0;
         right_scan    = 0;
         clear_scan();
         keep_slat     = '0;
         keep_slon     = '0;
         keep_elat     = '0;
         keep_elon     = '0;
         keep_mid      = '0;
         any_good_scan = 0;
         ref_lat       = REF_LAT_RST;
         last_head     = HEAD_UNKNOWN;
         head_scan     = '0;
         lines_due.delete();
         fail_count    = 0;
         lines_checked = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_LAT_STEP:  step_thr   = csr_wdata[23:0];
               CSR_DIR_SPACE: head_gap   = csr_wdata[15:0];
               CSR_PIX_SCAN:  scan_width = csr_wdata[PPS_W-1:0];
               CSR_NAV_MASK:  fail_mask  = csr_wdata[31:0];
               CSR_SCAN_DIR:  right_scan = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (track_pixel(req_pixel_lat, req_pixel_lon, req_pixel_flags,
                            req_scan_number, req_end_of_scan, req_final_scan,
                            next_line))
               lines_due.push_back(next_line);
         end
         if (rsp_valid && rsp_ready) begin
            if (lines_due.size() == 0) begin
               $error("line beat for scan %0d with no line due", rsp_line_number);
               fail_count++;
            end else begin
               oldest = lines_due.pop_front();
               check_field("start_lat", oldest.start_lat, rsp_start_lat);
               check_field("start_lon", oldest.start_lon, rsp_start_lon);
               check_field("end_lat", oldest.end_lat, rsp_end_lat);
               check_field("end_lon", oldest.end_lon, rsp_end_lon);
               check_field("centre_lat", oldest.centre_lat, rsp_centre_lat);
               check_field("line_number", 32'(oldest.line_number), 32'(rsp_line_number));
               check_field("why", 32'(oldest.why), 32'(rsp_why));
               lines_checked++;
            end
         end
      end
      lines_pending = lines_due.size();
   end

endmodule

[bench/scan_footprint_line_selector_top_tb.sv]
module scan_footprint_line_selector_top_tb;
   import sfls_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEG               = 65536;
   localparam int ITEMS_PER_SETTING = 55;
   localparam int CYCLE_LIMIT       = 1000000;

   logic                  clock;
   logic                  reset;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_ready;
   logic signed [31:0]    req_pixel_lat;
   logic signed [31:0]    req_pixel_lon;
   logic [31:0]           req_pixel_flags;
   logic [15:0]           req_scan_number;
   logic                  req_end_of_scan;
   logic                  req_final_scan;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic signed [31:0]    rsp_start_lat;
   logic signed [31:0]    rsp_start_lon;
   logic signed [31:0]    rsp_end_lat;
   logic signed [31:0]    rsp_end_lon;
   logic signed [31:0]    rsp_centre_lat;
   logic [15:0]           rsp_line_number;
   logic [1:0]            rsp_why;

   int fail_count;
   int lines_pending;
   int lines_checked;

   // stimulus-side view of the registers
   int          thr_cfg;
   int          width_cfg;
   logic [31:0] mask_cfg;

   logic [15:0] scan_no;
   int          track_lat;
   int          track_dir;
   int          items_sent;
   int          settings_used;
   int          cycle_count;
   bit          steady;

   scan_footprint_line_selector_top DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_lat   (req_pixel_lat),
      .req_pixel_lon   (req_pixel_lon),
      .req_pixel_flags (req_pixel_flags),
      .req_scan_number (req_scan_number),
      .req_end_of_scan (req_end_of_scan),
      .req_final_scan  (req_final_scan),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_start_lat   (rsp_start_lat),
      .rsp_start_lon   (rsp_start_lon),
      .rsp_end_lat     (rsp_end_lat),
      .rsp_end_lon     (rsp_end_lon),
      .rsp_centre_lat  (rsp_centre_lat),
      .rsp_line_number (rsp_line_number),
      .rsp_why         (rsp_why)
   );

   sfls_line_checker line_check (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_lat   (req_pixel_lat),
      .req_pixel_lon   (req_pixel_lon),
      .req_pixel_flags (req_pixel_flags),
      .req_scan_number (req_scan_number),
      .req_end_of_scan (req_end_of_scan),
      .req_final_scan  (req_final_scan),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_start_lat   (rsp_start_lat),
      .rsp_start_lon   (rsp_start_lon),
      .rsp_end_lat     (rsp_end_lat),
      .rsp_end_lon     (rsp_end_lon),
      .rsp_centre_lat  (rsp_centre_lat),
      .rsp_line_number (rsp_line_number),
      .rsp_why         (rsp_why),
      .fail_count      (fail_count),
      .lines_pending   (lines_pending),
      .lines_checked   (lines_checked)
   );

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d lines still due", cycle_count, lines_pending);
      $display("scan_footprint_line_selector_top_tb: FAIL");
      $finish;
   end

   // line beat back-pressure: mostly open, short stalls, a few long ones
   initial begin
      int r;
      int hold;
      int open;
      hold = 0;
      open = 0;
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (open > 0) begin
            rsp_ready = 1;
            open--;
         end else if (hold > 0) begin
            rsp_ready = 0;
            hold--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_ready = 1;
            end else if (r < 70) begin
               rsp_ready = 1;
               open = $urandom_range(20, 60);
            end else if (r < 94) begin
               rsp_ready = 0;
               hold = $urandom_range(0, 2);
            end else begin
               rsp_ready = 0;
               hold = $urandom_range(9, 25);
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int clamp_lat(input int v);
      if (v > 90 * DEG) return 90 * DEG;
      if (v < -90 * DEG) return -90 * DEG;
      return v;
   endfunction

   function automatic int random_lon();
      return int'($urandom_range(0, 360 * DEG)) - 180 * DEG;
   endfunction

   // one pixel beat, held until accepted
   task automatic put_pixel(input logic signed [31:0] lat, input logic signed [31:0] lon,
                            input logic [31:0] flags, input bit eos, input bit fin);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       = 1;
      req_pixel_lat   = lat;
      req_pixel_lon   = lon;
      req_pixel_flags = flags;
      req_scan_number = scan_no;
      req_end_of_scan = eos;
      req_final_scan  = fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // hold off until every due line has come back and the pipe is empty
   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (lines_pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_register(input logic [CSR_IDX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write = 1;
      csr_index = idx;
      csr_wdata = data;
   endtask

   task automatic apply_setting(input int thr, input int spacing, input int width,
                                input logic [31:0] mask, input bit flip);
      drain();
      set_register(CSR_LAT_STEP, thr);
      set_register(CSR_DIR_SPACE, spacing);
      set_register(CSR_PIX_SCAN, width);
      set_register(CSR_NAV_MASK, mask);
      set_register(CSR_SCAN_DIR, CSR_DATA_W'(flip));
      @(negedge clock);
      csr_write   = 0;
      thr_cfg     = thr;
      width_cfg   = width;
      mask_cfg    = mask;
      settings_used++;
   endtask

   // move the ground track: drift, reversals, jumps, pole visits
   task automatic next_scan();
      int step;
      if ($urandom_range(0, 9) == 0) begin
         if ($urandom_range(0, 1))
            track_lat = int'($urandom_range(75 * DEG + 1, 89 * DEG));
         else
            track_lat = int'($urandom_range(0, 180 * DEG)) - 90 * DEG;
         if ($urandom_range(0, 1)) track_lat = -track_lat;
      end else begin
         if ($urandom_range(0, 3) == 0) track_dir = -track_dir;
         if ($urandom_range(0, 5) == 0)
            step = thr_cfg + int'($urandom_range(1, 3 * DEG));
         else
            step = int'($urandom_range(0, thr_cfg / 2 + 2000));
         track_lat = clamp_lat(track_lat + track_dir * step);
      end
      if ($urandom_range(0, 11) == 0)
         scan_no = 16'($urandom_range(0, 65535));
      else
         scan_no++;
   endtask

   // a scan of mostly good pixels near the track, with some bad ones
   task automatic random_scan();
      int                 len;
      int                 top_len;
      logic signed [31:0] lat;
      logic signed [31:0] lon;
      logic [31:0]        flags;
      bit                 last;
      top_len = (width_cfg < 10) ? width_cfg + 2 : 12;
      len     = $urandom_range(1, top_len);
      steady  = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
         last = (i == len - 1);
         lat  = clamp_lat(track_lat + int'($urandom_range(0, 511)) - 256);
         lon  = random_lon();
         flags = $urandom & ~mask_cfg;
         if ($urandom_range(0, 99) < 10) begin
            case ($urandom_range(0, 3))
               0: begin
                  lat   = $urandom;
                  lon   = $urandom;
                  flags = $urandom;
               end
               1: begin
                  lat = LAT_MAX + int'($urandom_range(1, 3));
                  if ($urandom_range(0, 1)) lat = -lat;
               end
               2: begin
                  lon = LON_MAX + int'($urandom_range(1, 3));
                  if ($urandom_range(0, 1)) lon = -lon;
               end
               default: begin
                  flags = $urandom;
               end
            endcase
         end
         put_pixel(lat, lon, flags, last,
                   last ? ($urandom_range(0, 5) == 0) : ($urandom_range(0, 1) == 1));
      end
      next_scan();
   endtask

   task automatic run_random(input int count);
      int start;
      start = items_sent;
      while (items_sent - start < count) random_scan();
   endtask

   initial begin
      reset           = 1;
      csr_write       = 0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_valid       = 0;
      req_pixel_lat   = '0;
      req_pixel_lon   = '0;
      req_pixel_flags = '0;
      req_scan_number = '0;
      req_end_of_scan = 0;
      req_final_scan  = 0;
      thr_cfg         = 65536;
      width_cfg       = 1024;
      mask_cfg        = '0;
      scan_no         = '0;
      track_lat       = 0;
      track_dir       = 1;
      items_sent      = 0;
      settings_used   = 1;
      steady          = 0;
      repeat (3) @(negedge clock);
      reset = 0;

      // final scan before any good scan reports zero bounds
      scan_no = 16'd0;
      put_pixel(LAT_MAX + 1, 0, '0, 1, 1);

      // out of range low in latitude and on both sides in longitude, no line
      scan_no = 16'd1;
      put_pixel(32'sh8000_0000, 32'sh7fff_ffff, '1, 0, 1);
      put_pixel(LAT_MIN - 1, 0, '0, 0, 0);
      put_pixel(0, LON_MAX + 1, '0, 0, 0);
      put_pixel(0, LON_MIN - 1, '0, 1, 0);

      // first good scan, range limits are inclusive
      scan_no = 16'd2;
      put_pixel(LAT_MAX, LON_MIN, '1, 0, 0);
      put_pixel(32'sh7fff_ffff, 0, '0, 0, 0);
      put_pixel(LAT_MIN, LON_MAX, '0, 0, 0);
      put_pixel(10 * DEG, 20 * DEG, '0, 1, 0);

      // small move, then a move of exactly the threshold: both quiet
      scan_no = 16'd3;
      put_pixel(10 * DEG + DEG / 2, 0, '0, 1, 0);
      scan_no = 16'd4;
      put_pixel(11 * DEG, 5 * DEG, '0, 1, 0);

      // latitude step
      scan_no = 16'd5;
      put_pixel(30 * DEG, -5 * DEG, '0, 1, 0);

      // climb past 75 degrees, then turn back: pole turn
      scan_no = 16'd10;
      put_pixel(80 * DEG, 100 * DEG, '0, 1, 0);
      scan_no = 16'd16;
      put_pixel(80 * DEG + DEG / 2, 110 * DEG, '0, 1, 0);
      scan_no = 16'd22;
      put_pixel(80 * DEG - DEG / 4, 120 * DEG, '0, 1, 0);

      // step on a final scan reports the step only
      scan_no = 16'd23;
      put_pixel(-10 * DEG, -170 * DEG, '0, 1, 1);

      // scan number wraps
      scan_no = 16'hffff;
      put_pixel(-10 * DEG - 100, -171 * DEG, '0, 1, 0);
      scan_no = 16'd0;
      put_pixel(-76 * DEG, 0, '0, 1, 0);

      // final scan with no good pixel repeats the last good bounds
      scan_no = 16'd1;
      put_pixel(LAT_MAX + 1, 0, '0, 1, 1);

      // random scans under reset settings, then under the extremes
      run_random(ITEMS_PER_SETTING);
      apply_setting(0, 0, 1, 32'hffff_ffff, 1'b1);
      run_random(ITEMS_PER_SETTING);
      apply_setting(11796480, 65535, MAX_PIXELS, '0, 1'b0);
      run_random(ITEMS_PER_SETTING);

      // random settings with small widths and thresholds that allow pole turns
      repeat (4) begin
         apply_setting($urandom_range(0, 4 * DEG), $urandom_range(0, 3),
                       $urandom_range(2, 16), $urandom & $urandom & $urandom,
                       $urandom_range(0, 1) == 1);
         run_random(ITEMS_PER_SETTING);
      end

      drain();
      repeat (10) @(negedge clock);
      $display("run covered %0d pixel beats and %0d line beats under %0d register settings",
               items_sent, lines_checked, settings_used);
      $display("widths from 1 to %0d pixels, thresholds from 0 to 180 degrees, both directions",
               MAX_PIXELS);
      if (fail_count == 0 && lines_pending == 0)
         $display("scan_footprint_line_selector_top_tb: PASS");
      else
         $display("scan_footprint_line_selector_top_tb: FAIL");
      $finish;
   end

endmodule

[scan_footprint_line_selector_top.f]
+incdir+rtl
rtl/sfls_pkg.sv
rtl/sfls_csr_regs.sv
rtl/sfls_pixel_stage.sv
rtl/sfls_line_tracker.sv
rtl/scan_footprint_line_selector_top.sv
rtl/sfls_checker.sv
bench/sfls_line_checker.sv
bench/scan_footprint_line_selector_top_tb.sv
